/* src/tcw_pkg.sv */
// tcw_pkg: shared types and constants of the text console writer
// request and result structs, operation codes, cell layout, default geometry
// no dependencies
package tcw_pkg;

  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_column;
  } tcw_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [COL_W-1:0]  cursor_column_out;
  } tcw_rsp_t;

endpackage

/* src/tcw_screen_ram.sv */
// tcw_screen_ram: screen store, one write port and one registered read port
// depends on tcw_pkg for the cell width
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int Depth = TCW_COLUMNS * TCW_ROWS,
  localparam int AW   = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [Depth];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/text_console_writer_core.sv */
// text_console_writer_core: console with cursor, scroll and clear; uses tcw_pkg, tcw_screen_ram
// put writes in S_WRITE; plain newline and unknown op end in S_IDLE; read ends in S_READ
// a scroll runs a copy pass then a blank row on the store write port
// clear writes every cell, one cell written per cycle
// after reset busy stays high while S_INIT blanks the store
// one request at a time, the next accepted as its result strobes; results cannot be stalled
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tcw_req_t          req_i,
  output logic              result_valid_o,
  output tcw_rsp_t          rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ATTR_W-1:0] cfg_attr_i
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int MRW   = (RW > ROW_W) ? RW : ROW_W;
  localparam int MCW   = (CW > COL_W) ? CW : COL_W;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              pend_q, pend_d;
  logic              rdok_q, rdok_d;
  logic [ATTR_W-1:0] attr_q;
  logic              done_q;
  tcw_rsp_t          rsp_q, rsp_d;
  logic              fin;
  logic [CHAR_W-1:0] cell_char_d;
  logic [ATTR_W-1:0] cell_attr_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_wa, ram_ra;
  logic [CELL_W-1:0] ram_wd, ram_rd;

  // shared address unit: row * columns + column
  logic [MRW-1:0]    mul_row;
  logic [MCW-1:0]    mul_col;
  logic [AW-1:0]     mul_addr;
  logic              rd_in_range;
  logic              row_last, col_wrap, idx_last;

  always_comb begin
    if (state_q == S_IDLE) begin
      mul_row = MRW'(req_i.read_row);
      mul_col = MCW'(req_i.read_column);
    end else begin
      mul_row = MRW'(row_q);
      mul_col = MCW'(col_q);
    end
    mul_addr = AW'(32'(mul_row) * 32'(COLUMNS) + 32'(mul_col));
  end

  assign rd_in_range = (32'(req_i.read_row) < 32'(ROWS)) &&
                       (32'(req_i.read_column) < 32'(COLUMNS));
  assign row_last    = (32'(row_q) == 32'(ROWS - 1));
  assign col_wrap    = (32'(col_q) == 32'(COLUMNS));
  assign idx_last    = (32'(idx_q) == 32'(CELLS - 1));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    idx_d       = idx_q;
    char_d      = char_q;
    pend_d      = pend_q;
    rdok_d      = rdok_q;
    fin         = 1'b0;
    cell_char_d = '0;
    cell_attr_d = '0;
    ram_we      = 1'b0;
    ram_wa      = idx_q;
    ram_wd      = {attr_q, SPACE_CODE};
    ram_re      = 1'b0;
    ram_ra      = mul_addr;
    case (state_q)
      S_INIT: begin
        ram_we = 1'b1;
        ram_wd = {RESET_ATTR, SPACE_CODE};
        if (idx_last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (req_i.operation)
            OP_PUT: begin
              char_d = req_i.char_code;
              if (req_i.char_code == NEWLINE_CODE) begin
                col_d = '0;
                if (row_last) begin
                  pend_d  = 1'b0;
                  idx_d   = '0;
                  state_d = S_SCROLL;
                end else begin
                  row_d = row_q + 1'b1;
                  fin   = 1'b1;
                end
              end else if (col_wrap) begin
                col_d = '0;
                if (row_last) begin
                  pend_d  = 1'b1;
                  idx_d   = '0;
                  state_d = S_SCROLL;
                end else begin
                  row_d   = row_q + 1'b1;
                  state_d = S_WRITE;
                end
              end else begin
                state_d = S_WRITE;
              end
            end
            OP_READ: begin
              rdok_d  = rd_in_range;
              ram_re  = rd_in_range;
              state_d = S_READ;
            end
            OP_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              idx_d   = '0;
              state_d = S_CLEAR;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_WRITE: begin
        ram_we  = 1'b1;
        ram_wa  = mul_addr;
        ram_wd  = {attr_q, char_q};
        col_d   = col_q + 1'b1;
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      S_READ: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        if (rdok_q) begin
          cell_char_d = ram_rd[CHAR_W-1:0];
          cell_attr_d = ram_rd[CELL_W-1:CHAR_W];
        end
      end
      S_SCROLL: begin
        ram_we = 1'b1;
        ram_wd = ram_rd;
        if (32'(idx_q) == 32'(CELLS - COLUMNS - 1)) begin
          idx_d   = AW'(CELLS - COLUMNS);
          state_d = S_BLANK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (idx_last) begin
          if (pend_q) begin
            state_d = S_WRITE;
          end else begin
            fin     = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_last) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // copy pass reads one row ahead of the write
    if (state_d == S_SCROLL) begin
      ram_re = 1'b1;
      ram_ra = AW'(32'(idx_d) + 32'(COLUMNS));
    end
    rsp_d.cell_char         = cell_char_d;
    rsp_d.cell_attr         = cell_attr_d;
    rsp_d.cursor_row_out    = ROW_W'(row_d);
    rsp_d.cursor_column_out = COL_W'(col_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      rdok_q  <= 1'b0;
      attr_q  <= RESET_ATTR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      rdok_q  <= rdok_d;
      done_q  <= fin;
      if (cfg_valid_i) begin
        attr_q <= cfg_attr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    if (fin) begin
      rsp_q <= rsp_d;
    end
  end

  tcw_screen_ram #(
    .Depth (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .re_i    (ram_re),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  assign busy           = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = done_q;
  assign rsp_o          = rsp_q;

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_request_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("request accepted without work or result");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !ram_we)
    else $error("store written while idle");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < 32'(ROWS)) && (32'(col_q) <= 32'(COLUMNS)))
    else $error("cursor out of range");

  a_busy_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

endmodule

/* tb/tb_text_console_writer_core.sv */
// tb_text_console_writer_core: self-checking bench for the text console writer
// a directed table then random phases under several attributes; each result is checked
// against its typed table row or a shadow screen and cursor model; depends on tcw_pkg and the core
module tb_text_console_writer_core
  import tcw_pkg::*;
();

  localparam int CELLS = TCW_ROWS * TCW_COLUMNS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    tcw_req_t req;
    logic     typed;
    tcw_rsp_t rsp;
  } dir_row_t;

  localparam int DIR_ROWS = 16;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{OP_READ,   8'h00, 5'd0,  7'd0},   1'b1, '{SPACE_CODE, RESET_ATTR, 5'd0, 7'd0}},
    '{'{OP_READ,   8'h00, 5'd24, 7'd79},  1'b1, '{SPACE_CODE, RESET_ATTR, 5'd0, 7'd0}},
    '{'{OP_READ,   8'h00, 5'd25, 7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_READ,   8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_READ,   8'h00, 5'd0,  7'd80},  1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_UNUSED, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_PUT,    8'h41, 5'd0,  7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
    '{'{OP_PUT,    8'hFF, 5'd0,  7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
    '{'{OP_PUT,    8'h00, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd3}},
    '{'{OP_READ,   8'h00, 5'd0,  7'd1},   1'b1, '{8'hFF, RESET_ATTR, 5'd0, 7'd3}},
    '{'{OP_PUT,    NEWLINE_CODE, 5'd0, 7'd0}, 1'b1, '{8'h00, 8'h00, 5'd1, 7'd0}},
    '{'{OP_PUT,    8'h80, 5'd31, 7'd127}, 1'b0, '0},
    '{'{OP_READ,   8'hFF, 5'd1,  7'd0},   1'b0, '0},
    '{'{OP_CLEAR,  8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
    '{'{OP_READ,   8'h00, 5'd0,  7'd1},   1'b1, '{SPACE_CODE, RESET_ATTR, 5'd0, 7'd0}},
    '{'{OP_READ,   8'h00, 5'd1,  7'd0},   1'b0, '0}
  };

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  tcw_req_t          req_i       = '0;
  logic              result_valid_o;
  tcw_rsp_t          rsp_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [ATTR_W-1:0] cfg_attr_i  = '0;

  text_console_writer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_attr_i     (cfg_attr_i)
  );

  // shadow of the console
  logic [CELL_W-1:0] shadow_screen [CELLS];
  logic [ROW_W-1:0]  cur_row  = '0;
  logic [COL_W-1:0]  cur_col  = '0;
  logic [ATTR_W-1:0] cur_attr = RESET_ATTR;

  tcw_rsp_t expected_rsp_q [$];

  int error_count     = 0;
  int results_checked = 0;
  int request_count   = 0;
  int put_count       = 0;
  int read_count      = 0;
  int clear_count     = 0;
  int scroll_count    = 0;
  int wrap_nl_count   = 0;
  int burst_left      = 0;
  bit idle_enable     = 1'b1;

  function automatic void fill_screen(input logic [ATTR_W-1:0] a);
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {a, SPACE_CODE};
  endfunction

  function automatic void next_line();
    cur_col = '0;
    if (int'(cur_row) == TCW_ROWS - 1) begin
      for (int i = 0; i < CELLS - TCW_COLUMNS; i++)
        shadow_screen[i] = shadow_screen[i + TCW_COLUMNS];
      for (int i = CELLS - TCW_COLUMNS; i < CELLS; i++)
        shadow_screen[i] = {cur_attr, SPACE_CODE};
      scroll_count++;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic tcw_rsp_t console_step(input tcw_req_t r);
    tcw_rsp_t rsp;
    int idx;
    rsp = '0;
    case (r.operation)
      OP_PUT: begin
        put_count++;
        if (r.char_code == NEWLINE_CODE) begin
          if (int'(cur_col) == TCW_COLUMNS) wrap_nl_count++;
          next_line();
        end else begin
          if (int'(cur_col) >= TCW_COLUMNS) next_line();
          idx = int'(cur_row) * TCW_COLUMNS + int'(cur_col);
          shadow_screen[idx] = {cur_attr, r.char_code};
          cur_col++;
        end
      end
      OP_READ: begin
        read_count++;
        if (int'(r.read_row) < TCW_ROWS && int'(r.read_column) < TCW_COLUMNS) begin
          idx = int'(r.read_row) * TCW_COLUMNS + int'(r.read_column);
          {rsp.cell_attr, rsp.cell_char} = shadow_screen[idx];
        end
      end
      OP_CLEAR: begin
        clear_count++;
        fill_screen(cur_attr);
        cur_row = '0;
        cur_col = '0;
      end
      default: ;
    endcase
    rsp.cursor_row_out    = cur_row;
    rsp.cursor_column_out = cur_col;
    return rsp;
  endfunction

  task automatic send_request(input tcw_req_t r, input logic typed, input tcw_rsp_t typed_rsp);
    tcw_rsp_t predicted;
    if (burst_left == 0) begin
      if (idle_enable) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    burst_left--;
    request_count++;
    predicted = console_step(r);
    expected_rsp_q.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] a);
    wait_idle();
    cfg_attr_i  <= a;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_attr = a;
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] c);
    tcw_req_t r;
    r.operation   = OP_PUT;
    r.char_code   = c;
    r.read_row    = 5'($urandom);
    r.read_column = 7'($urandom);
    send_request(r, 1'b0, '0);
  endtask

  task automatic send_read(input int row, input int col);
    tcw_req_t r;
    r.operation   = OP_READ;
    r.char_code   = 8'($urandom);
    r.read_row    = 5'(row);
    r.read_column = 7'(col);
    send_request(r, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #80000000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : result_check
    tcw_rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result with no request outstanding: %p", rsp_o);
        error_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("cell_char", want.cell_char, rsp_o.cell_char);
        check_field("cell_attr", want.cell_attr, rsp_o.cell_attr);
        check_field("cursor_row_out", 8'(want.cursor_row_out), 8'(rsp_o.cursor_row_out));
        check_field("cursor_column_out", 8'(want.cursor_column_out),
                    8'(rsp_o.cursor_column_out));
        results_checked++;
      end
    end
  end

  initial begin
    tcw_req_t r;
    logic [CHAR_W-1:0] c;
    logic [ATTR_W-1:0] a;
    int pick;
    int n;
    int phase_end;
    fill_screen(RESET_ATTR);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].rsp);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: a = 8'h00;
        1: a = 8'hFF;
        5: a = RESET_ATTR;
        default: a = 8'($urandom);
      endcase
      write_attribute(a);
      idle_enable = (ph != 2);
      phase_end = request_count + 80;
      while (request_count < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // noise: every field random, unused operation included
          r.operation   = 2'($urandom);
          r.char_code   = 8'($urandom);
          r.read_row    = 5'($urandom);
          r.read_column = 7'($urandom);
          send_request(r, 1'b0, '0);
        end else if (pick < 65) begin
          // a line of text, full width lines start on a fresh row
          n = ($urandom_range(0, 9) < 3) ? TCW_COLUMNS : $urandom_range(1, TCW_COLUMNS - 1);
          if (n == TCW_COLUMNS && cur_col != 0) send_put(NEWLINE_CODE);
          repeat (n) begin
            do c = 8'($urandom); while (c == NEWLINE_CODE);
            send_put(c);
          end
          if ($urandom_range(0, 1)) send_put(NEWLINE_CODE);
        end else if (pick < 80) begin
          repeat ($urandom_range(5, 30)) send_put(NEWLINE_CODE);
        end else if (pick < 97) begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1))
              send_read(int'(cur_row), $urandom_range(0, TCW_COLUMNS - 1));
            else
              send_read($urandom_range(0, TCW_ROWS - 1), $urandom_range(0, TCW_COLUMNS - 1));
          end
        end else begin
          r.operation   = OP_CLEAR;
          r.char_code   = 8'($urandom);
          r.read_row    = 5'($urandom);
          r.read_column = 7'($urandom);
          send_request(r, 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (CELLS + 100) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) begin
      $error("%0d results never arrived", expected_rsp_q.size());
      error_count++;
    end

    $display("run covered %0d requests: %0d puts, %0d reads, %0d clears, %0d checked results",
             request_count, put_count, read_count, clear_count, results_checked);
    $display("scrolls seen %0d, newlines with wrap pending %0d, mismatches %0d",
             scroll_count, wrap_nl_count, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
